/* hw/rtl/sync_frame_sum_check_receiver_core_assert.svh */
// Assertion macros used by the checker module of the frame receiver.
// Expects signals named clk and rst in the scope of each use.
`ifndef SYNC_FRAME_SUM_CHECK_RECEIVER_CORE_ASSERT_SVH
`define SYNC_FRAME_SUM_CHECK_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication, disabled during reset.
`define SFSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

/* hw/rtl/sfsc_pkg.sv */
// Package of the sync frame receiver: sizes, status codes, job and write types.
// Depends on nothing; used by every module of the block.
package sfsc_pkg;

  localparam int MAX_PAYLOAD = 15;
  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam int SUM_W = 16;
  localparam int IDX_W = 5;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int PIDX_W = LEN_W;
  localparam int POS_W = $clog2(MAX_PAYLOAD + 5);
  localparam int MEM_DEPTH = 2 * MAX_PAYLOAD;
  localparam int MADDR_W = $clog2(MEM_DEPTH);

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_SUM_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LEN,
    BK_PAY
  } back_state_t;

  typedef struct packed {
    status_t              status;
    logic                 bufsel;
    logic [7:0]           cmd;
    logic [LEN_W-1:0]     len;
  } job_t;

  typedef struct packed {
    logic                 we;
    logic                 bufsel;
    logic [PIDX_W-1:0]    addr;
    logic [7:0]           data;
  } pay_wr_t;

endpackage

/* hw/rtl/sync_frame_sum_check_receiver_core.sv */
// Top level of the sync frame receiver with additive checksum.
// Depends on sfsc_pkg, sfsc_front, sfsc_job_queue and sfsc_back.
//
//   Channel  Handshake        Payload
//   input    push / full      rx_byte
//   result   pop / empty      data_byte, byte_index, last, status
//
// A byte is taken when push is high and full is low. A frame's job enters
// the queue on the cycle of its last byte: the low checksum byte, or the
// length byte when the length is too large.
// The first item of a job reaches the result ports through the queue and the
// output register. A good frame gives length + 2 items, one per cycle while
// pop is high; an error gives one item. The emission sequencer sets this rate.
// full is high while two jobs are held in the queue, the one being played out
// included. rst is synchronous and empties the queue and the output register.
module sync_frame_sum_check_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  data_byte,
  output logic [4:0]  byte_index,
  output logic        last,
  output logic [1:0]  status
);

  logic               accept;
  logic               job_push;
  sfsc_pkg::job_t     job;
  sfsc_pkg::pay_wr_t  pay_wr;
  logic               head_valid;
  sfsc_pkg::job_t     head;
  logic               q_pop;
  logic               out_valid;

  assign accept = push && !full;
  assign empty = !out_valid;

  sfsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .job_push (job_push),
    .job      (job),
    .pay_wr   (pay_wr)
  );

  sfsc_job_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (job),
    .pop        (q_pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  sfsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pay_wr     (pay_wr),
    .head_valid (head_valid),
    .head       (head),
    .q_pop      (q_pop),
    .pop        (pop),
    .out_valid  (out_valid),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .last       (last),
    .status     (status)
  );

endmodule

/* hw/rtl/sfsc_front.sv */
// Front part: parses received bytes, keeps the checksum and payload writes,
// and posts one job per finished frame. Depends on sfsc_pkg.
module sfsc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           rx_byte,
  output logic                 job_push,
  output sfsc_pkg::job_t       job,
  output sfsc_pkg::pay_wr_t    pay_wr
);

  localparam logic [sfsc_pkg::POS_W-1:0] POS_HUNT = sfsc_pkg::POS_W'(0);
  localparam logic [sfsc_pkg::POS_W-1:0] POS_CMD  = sfsc_pkg::POS_W'(1);
  localparam logic [sfsc_pkg::POS_W-1:0] POS_LEN  = sfsc_pkg::POS_W'(2);
  localparam logic [sfsc_pkg::POS_W-1:0] POS_DATA = sfsc_pkg::POS_W'(3);

  logic [sfsc_pkg::POS_W-1:0] position, position_next;
  logic [sfsc_pkg::LEN_W-1:0] frame_length, frame_length_next;
  logic [7:0]                 command_byte, command_byte_next;
  logic [sfsc_pkg::SUM_W-1:0] running_sum, running_sum_next;
  logic [7:0]                 check_high, check_high_next;
  logic                       wr_sel, wr_sel_next;
  logic [sfsc_pkg::POS_W-1:0] k;
  logic [sfsc_pkg::SUM_W-1:0] sum_add, sum_adj;
  logic                       sum_ok;

  always_comb begin
    k = position - POS_DATA;
    sum_add = running_sum + sfsc_pkg::SUM_W'(rx_byte);
    sum_adj = (running_sum[7:0] == 8'hFF) ? {running_sum[sfsc_pkg::SUM_W-2:0], 1'b0}
                                          : running_sum;
    sum_ok = (sum_adj == {check_high, rx_byte});
  end

  always_comb begin
    position_next = position;
    frame_length_next = frame_length;
    command_byte_next = command_byte;
    running_sum_next = running_sum;
    check_high_next = check_high;
    wr_sel_next = wr_sel;
    job_push = 1'b0;
    job.status = sfsc_pkg::ST_GOOD;
    job.bufsel = wr_sel;
    job.cmd = command_byte;
    job.len = frame_length;
    pay_wr.we = 1'b0;
    pay_wr.bufsel = wr_sel;
    pay_wr.addr = k[sfsc_pkg::PIDX_W-1:0];
    pay_wr.data = rx_byte;
    if (accept) begin
      priority if (rx_byte == sfsc_pkg::SYNC_BYTE) begin
        position_next = POS_CMD;
        running_sum_next = sfsc_pkg::SUM_W'(sfsc_pkg::SYNC_BYTE);
      end else if (position == POS_HUNT) begin
        position_next = POS_HUNT;
      end else if (position == POS_CMD) begin
        command_byte_next = rx_byte;
        running_sum_next = sum_add;
        position_next = POS_LEN;
      end else if (position == POS_LEN) begin
        if (rx_byte > 8'(sfsc_pkg::MAX_PAYLOAD)) begin
          position_next = POS_HUNT;
          job_push = 1'b1;
          job.status = sfsc_pkg::ST_LEN_ERR;
        end else begin
          frame_length_next = rx_byte[sfsc_pkg::LEN_W-1:0];
          running_sum_next = sum_add;
          position_next = POS_DATA;
        end
      end else if (k < sfsc_pkg::POS_W'(frame_length)) begin
        pay_wr.we = 1'b1;
        running_sum_next = sum_add;
        position_next = position + sfsc_pkg::POS_W'(1);
      end else if (k == sfsc_pkg::POS_W'(frame_length)) begin
        check_high_next = rx_byte;
        position_next = position + sfsc_pkg::POS_W'(1);
      end else begin
        position_next = POS_HUNT;
        job_push = 1'b1;
        if (sum_ok) begin
          wr_sel_next = ~wr_sel;
        end else begin
          job.status = sfsc_pkg::ST_SUM_ERR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= POS_HUNT;
      frame_length <= '0;
      running_sum <= '0;
      wr_sel <= 1'b0;
    end else begin
      position <= position_next;
      frame_length <= frame_length_next;
      running_sum <= running_sum_next;
      wr_sel <= wr_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    command_byte <= command_byte_next;
    check_high <= check_high_next;
  end

endmodule

/* hw/rtl/sfsc_job_queue.sv */
// Two-entry queue of frame jobs between the front and back parts.
// Depends on sfsc_pkg.
module sfsc_job_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sfsc_pkg::job_t       push_job,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output sfsc_pkg::job_t       head
);

  sfsc_pkg::job_t entry [2];
  logic           wptr, rptr;
  logic [1:0]     count;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head = entry[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_job;
    end
  end

endmodule

/* hw/rtl/sfsc_back.sv */
// Back part: holds the two payload buffers and plays each job out as result
// items into the output register. Depends on sfsc_pkg.
module sfsc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sfsc_pkg::pay_wr_t    pay_wr,
  input  logic                 head_valid,
  input  sfsc_pkg::job_t       head,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 out_valid,
  output logic [7:0]           data_byte,
  output logic [sfsc_pkg::IDX_W-1:0] byte_index,
  output logic                 last,
  output logic [1:0]           status
);

  sfsc_pkg::back_state_t         state, state_next;
  logic [sfsc_pkg::PIDX_W-1:0]   pidx, pidx_next;
  logic [7:0]                    mem [sfsc_pkg::MEM_DEPTH];
  logic [7:0]                    rd_data;
  logic [sfsc_pkg::MADDR_W-1:0]  waddr, raddr;
  logic                          load, out_load, pay_last, len_zero;
  logic [7:0]                    data_next;
  logic [sfsc_pkg::IDX_W-1:0]    index_next;
  logic                          last_next;
  sfsc_pkg::status_t             status_next;

  assign load = !out_valid || pop;
  assign pay_last = ((pidx + sfsc_pkg::PIDX_W'(1)) == head.len);
  assign len_zero = (head.len == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      sfsc_pkg::BK_IDLE: begin
        if (head_valid && load && head.status == sfsc_pkg::ST_GOOD) begin
          state_next = sfsc_pkg::BK_LEN;
        end
      end
      sfsc_pkg::BK_LEN: begin
        if (load) begin
          state_next = len_zero ? sfsc_pkg::BK_IDLE : sfsc_pkg::BK_PAY;
        end
      end
      sfsc_pkg::BK_PAY: begin
        if (load && pay_last) begin
          state_next = sfsc_pkg::BK_IDLE;
        end
      end
      default: state_next = sfsc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    q_pop = 1'b0;
    pidx_next = pidx;
    data_next = 8'd0;
    index_next = '0;
    last_next = 1'b1;
    status_next = sfsc_pkg::ST_GOOD;
    unique case (state)
      sfsc_pkg::BK_IDLE: begin
        if (head_valid && load) begin
          out_load = 1'b1;
          if (head.status == sfsc_pkg::ST_GOOD) begin
            data_next = head.cmd;
            last_next = 1'b0;
          end else begin
            status_next = head.status;
            q_pop = 1'b1;
          end
        end
      end
      sfsc_pkg::BK_LEN: begin
        pidx_next = '0;
        if (load) begin
          out_load = 1'b1;
          data_next = 8'(head.len);
          index_next = sfsc_pkg::IDX_W'(1);
          last_next = len_zero;
          q_pop = len_zero;
        end
      end
      sfsc_pkg::BK_PAY: begin
        if (load) begin
          out_load = 1'b1;
          data_next = rd_data;
          index_next = sfsc_pkg::IDX_W'(pidx) + sfsc_pkg::IDX_W'(2);
          last_next = pay_last;
          q_pop = pay_last;
          pidx_next = pidx + sfsc_pkg::PIDX_W'(1);
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  always_comb begin
    waddr = pay_wr.bufsel
          ? sfsc_pkg::MADDR_W'(sfsc_pkg::MAX_PAYLOAD) + sfsc_pkg::MADDR_W'(pay_wr.addr)
          : sfsc_pkg::MADDR_W'(pay_wr.addr);
    raddr = head.bufsel
          ? sfsc_pkg::MADDR_W'(sfsc_pkg::MAX_PAYLOAD) + sfsc_pkg::MADDR_W'(pidx_next)
          : sfsc_pkg::MADDR_W'(pidx_next);
  end

  always_ff @(posedge clk) begin
    if (pay_wr.we) begin
      mem[waddr] <= pay_wr.data;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfsc_pkg::BK_IDLE;
      pidx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pidx <= pidx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      data_byte <= data_next;
      byte_index <= index_next;
      last <= last_next;
      status <= 2'(status_next);
    end
  end

endmodule

/* hw/rtl/sfsc_checker.sv */
// Port-level checker of the sync frame receiver, bound to the top level.
// Depends on sfsc_pkg and sync_frame_sum_check_receiver_core_assert.svh.
`include "sync_frame_sum_check_receiver_core_assert.svh"

module sfsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] data_byte,
  input logic [4:0] byte_index,
  input logic       last,
  input logic [1:0] status
);

  logic       err_item;
  logic       good_item;
  logic       run_more;
  logic [4:0] index_inc;

  assign err_item = !empty && (status != sfsc_pkg::ST_GOOD);
  assign good_item = !empty && (status == sfsc_pkg::ST_GOOD);
  assign run_more = !empty && pop && !last;
  assign index_inc = byte_index + 5'd1;

  `SFSC_ASSERT_IMPL(a_err_single, err_item, last)
  `SFSC_ASSERT_IMPL(a_err_zero, err_item, data_byte == 8'd0 && byte_index == 5'd0)
  `SFSC_ASSERT_NEXT(a_run_next, run_more, good_item && byte_index == $past(index_inc))
  `SFSC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(data_byte) && $stable(last))

endmodule

bind sync_frame_sum_check_receiver_core sfsc_checker u_sfsc_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for sync_frame_sum_check_receiver_core.
// Depends on sfsc_pkg and the receiver RTL. A directed table is followed by
// random frames; each result item is checked against a frame decoder or typed row.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 446;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [7:0]        data;
    logic [4:0]        index;
    logic              last;
    sfsc_pkg::status_t status;
  } frame_item_t;

  typedef struct packed {
    logic [7:0]        rx;
    logic              typed;
    sfsc_pkg::status_t st;
  } stim_row_t;

  localparam stim_row_t DIRECTED [24] = '{
    '{8'h00, 1'b0, sfsc_pkg::ST_GOOD}, '{8'h7E, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'hFF, 1'b0, sfsc_pkg::ST_GOOD}, '{8'h00, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'h00, 1'b0, sfsc_pkg::ST_GOOD}, '{8'h01, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'hFE, 1'b0, sfsc_pkg::ST_GOOD}, '{8'hFF, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'hFE, 1'b0, sfsc_pkg::ST_GOOD}, '{8'h10, 1'b1, sfsc_pkg::ST_LEN_ERR},
    '{8'hFF, 1'b0, sfsc_pkg::ST_GOOD}, '{8'h01, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'h00, 1'b0, sfsc_pkg::ST_GOOD}, '{8'h00, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'h00, 1'b1, sfsc_pkg::ST_SUM_ERR}, '{8'hFF, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'h05, 1'b0, sfsc_pkg::ST_GOOD}, '{8'h01, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'hFF, 1'b0, sfsc_pkg::ST_GOOD}, '{8'h02, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'h01, 1'b0, sfsc_pkg::ST_GOOD}, '{8'hFE, 1'b0, sfsc_pkg::ST_GOOD},
    '{8'h02, 1'b0, sfsc_pkg::ST_GOOD}, '{8'h00, 1'b0, sfsc_pkg::ST_GOOD}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] rx_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic       last;
  logic [1:0] status;

  logic              row_typed = 1'b0;
  sfsc_pkg::status_t row_status = sfsc_pkg::ST_GOOD;

  int send_idle_pct = 25;
  int recv_idle_pct = 75;
  int n_frame_bytes = 0;
  int errors = 0;
  int stall_cycles = 0;

  logic [4:0]  frm_pos = '0;
  logic [7:0]  frm_len = '0;
  logic [7:0]  frm_cmd = '0;
  logic [7:0]  frm_payload [sfsc_pkg::MAX_PAYLOAD];
  logic [15:0] frm_sum = '0;
  logic [7:0]  frm_chk_hi = '0;

  frame_item_t expected_items [$];
  frame_item_t want;

  sync_frame_sum_check_receiver_core dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .data_byte(data_byte), .byte_index(byte_index),
    .last(last), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_item(bit emit, logic [7:0] d, logic [4:0] idx, logic lst,
                                     sfsc_pkg::status_t st);
    frame_item_t it;
    if (emit) begin
      it.data = d;
      it.index = idx;
      it.last = lst;
      it.status = st;
      expected_items.push_back(it);
    end
  endfunction

  task automatic decode_rx_byte(input logic [7:0] b, input bit emit);
    logic [15:0] sum;
    int k;
    if (b == sfsc_pkg::SYNC_BYTE) begin
      frm_pos = 5'd1;
      frm_sum = 16'(sfsc_pkg::SYNC_BYTE);
    end else if (frm_pos == 5'd1) begin
      frm_cmd = b;
      frm_sum = frm_sum + b;
      frm_pos = 5'd2;
    end else if (frm_pos == 5'd2) begin
      if (b > sfsc_pkg::MAX_PAYLOAD) begin
        frm_pos = 5'd0;
        queue_item(emit, 8'h00, 5'd0, 1'b1, sfsc_pkg::ST_LEN_ERR);
      end else begin
        frm_len = b;
        frm_sum = frm_sum + b;
        frm_pos = 5'd3;
      end
    end else if (frm_pos != 5'd0) begin
      k = frm_pos - 3;
      if (k < frm_len) begin
        frm_payload[k] = b;
        frm_sum = frm_sum + b;
        frm_pos = frm_pos + 5'd1;
      end else if (k == frm_len) begin
        frm_chk_hi = b;
        frm_pos = frm_pos + 5'd1;
      end else begin
        frm_pos = 5'd0;
        sum = frm_sum;
        // A low byte of all ones could be mistaken for a sync, so the sum is doubled.
        if (sum[7:0] == 8'hFF) sum = sum << 1;
        if (sum != {frm_chk_hi, b}) begin
          queue_item(emit, 8'h00, 5'd0, 1'b1, sfsc_pkg::ST_SUM_ERR);
        end else begin
          queue_item(emit, frm_cmd, 5'd0, 1'b0, sfsc_pkg::ST_GOOD);
          queue_item(emit, frm_len, 5'd1, frm_len == 8'd0, sfsc_pkg::ST_GOOD);
          for (int i = 0; i < frm_len; i++)
            queue_item(emit, frm_payload[i], 5'(i + 2), (i + 1) == frm_len,
                       sfsc_pkg::ST_GOOD);
        end
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input sfsc_pkg::status_t st);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    row_typed <= typed;
    row_status <= st;
    do @(posedge clk); while (full);
  endtask

  task automatic send_frame_byte(input logic [7:0] b);
    send_byte(b, 1'b0, sfsc_pkg::ST_GOOD);
    n_frame_bytes++;
  endtask

  task automatic send_random_frame();
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] pay;
    logic [15:0] sum;
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(99);
    cmd = 8'($urandom_range(254));
    if (kind < 8) len = 8'($urandom_range(254, 16));
    else if (kind < 18) len = 8'(sfsc_pkg::MAX_PAYLOAD);
    else if (kind < 26) len = 8'd0;
    else len = 8'($urandom_range(sfsc_pkg::MAX_PAYLOAD));
    cut = (kind >= 26 && kind < 34) ? $urandom_range(len + 1) : 999;
    send_frame_byte(sfsc_pkg::SYNC_BYTE);
    send_frame_byte(cmd);
    send_frame_byte(len);
    if (kind < 8) return;
    sum = 16'(sfsc_pkg::SYNC_BYTE) + cmd + len;
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        send_frame_byte(sfsc_pkg::SYNC_BYTE);
        return;
      end
      pay = 8'($urandom_range(254));
      send_frame_byte(pay);
      sum = sum + pay;
    end
    if (cut == len) begin
      send_frame_byte(sfsc_pkg::SYNC_BYTE);
      return;
    end
    if (sum[7:0] == 8'hFF) sum = sum << 1;
    if (kind >= 34 && kind < 42) sum = sum ^ (16'd1 << $urandom_range(15));
    send_frame_byte(sum[15:8]);
    if (cut == len + 1) begin
      send_frame_byte(sfsc_pkg::SYNC_BYTE);
      return;
    end
    send_frame_byte(sum[7:0]);
  endtask

  always @(posedge clk) pop <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst) begin
      stall_cycles <= ((push && !full) || (pop && !empty)) ? 0 : stall_cycles + 1;
      if (push && !full) begin
        decode_rx_byte(rx_byte, !row_typed);
        if (row_typed) queue_item(1'b1, 8'h00, 5'd0, 1'b1, row_status);
      end
      if (pop && !empty) begin
        if (expected_items.size() == 0) begin
          $error("unexpected item: data_byte %0h byte_index %0d status %0d",
                 data_byte, byte_index, status);
          errors++;
        end else begin
          want = expected_items.pop_front();
          if (data_byte !== want.data) begin
            $error("data_byte expected %0h, got %0h", want.data, data_byte);
            errors++;
          end
          if (byte_index !== want.index) begin
            $error("byte_index expected %0d, got %0d", want.index, byte_index);
            errors++;
          end
          if (last !== want.last) begin
            $error("last expected %0b, got %0b", want.last, last);
            errors++;
          end
          if (status !== want.status) begin
            $error("status expected %0d, got %0d", want.status, status);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < $size(DIRECTED); r++)
      send_byte(DIRECTED[r].rx, DIRECTED[r].typed, DIRECTED[r].st);
    while (n_frame_bytes < RANDOM_ITEMS) begin
      if (n_frame_bytes >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n_frame_bytes >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 25;
      end
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(3, 1))
          send_byte(8'($urandom_range(255)), 1'b0, sfsc_pkg::ST_GOOD);
      send_random_frame();
    end
    push <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_items.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
